// ----- hw/rtl/tuf_pkg.sv -----
// shared constants, types and conversion functions for the texel unpack block
package tuf_pkg;

   localparam int unsigned LaneCount = 4;
   localparam int unsigned WordWidth = 32;

   typedef enum logic [1:0] {
      KIND_UNORM8 = 2'd0,
      KIND_HALF   = 2'd1,
      KIND_FLOAT  = 2'd2,
      KIND_RSVD   = 2'd3
   } kind_type;

   localparam logic [1:0] CSR_KIND  = 2'd0;
   localparam logic [1:0] CSR_COUNT = 2'd1;
   localparam logic [1:0] CSR_SWAP  = 2'd2;

   localparam logic [31:0] FloatOne = 32'h3F80_0000;

   // lane control handed from the top level to each lane
   typedef struct packed {
      kind_type kind;
      logic     present;
   } lane_ctl_type;

   // byte to single, b/255 correctly rounded
   function automatic logic [31:0] unorm8_to_single(input logic [7:0] b);
      logic [4:0]  lz;
      logic [7:0]  norm;
      logic [7:0]  ex;
      logic [47:0] q;
      logic [47:0] prod;
      logic [23:0] mant;
      logic        rbit;
      logic        sticky;
      logic [24:0] rnd;
      lz = 5'd0;
      norm = b;
      for (int i = 0; i < 7; i++) begin
         if (norm[7] == 1'b0) begin
            norm = {norm[6:0], 1'b0};
            lz = lz + 5'd1;
         end
      end
      // b/255 = b * 0x0.010101... (hex); b<<k in [128,255], value in [0.5,1)*2^-(k)
      // norm/255 in [128/255, 1]; compute norm * (2^40-1)/255 exactly from the repeating pattern
      prod = {40'd0, norm} * 48'h01_0101_0101;
      // prod = norm*(2^40-1)/255 exactly; norm*2^40/255 = prod + norm/255
      q = prod;
      if (norm == 8'hFF) begin
         return {1'b0, 8'd127, 23'd0};
      end
      // value = norm/255 = q / 2^40 + tiny, norm<255 so q < 2^40, q >= 2^39
      mant = q[39:16];
      rbit = q[15];
      sticky = 1'b1; // fractional part never exact, remainder nonzero
      rnd = {1'b0, mant} + {24'd0, rbit & (sticky | mant[0])};
      ex = 8'd126 - {3'd0, lz};
      if (b == 8'd0) begin
         return 32'd0;
      end
      if (rnd[24]) begin
         return {1'b0, ex + 8'd1, 23'd0};
      end
      return {1'b0, ex, rnd[22:0]};
   endfunction

   // fp16 to fp32, exact
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0] ex;
      logic [9:0] man;
      logic [3:0] sh;
      logic [10:0] m;
      ex = h[14:10];
      man = h[9:0];
      sh = 4'd0;
      m = {1'b0, man};
      if (ex == 5'd0) begin
         if (man == 10'd0) begin
            return {h[15], 31'd0};
         end
         for (int i = 0; i < 10; i++) begin
            if (m[10] == 1'b0) begin
               m = {m[9:0], 1'b0};
               sh = sh + 4'd1;
            end
         end
         return {h[15], 8'd113 - {4'd0, sh}, m[9:0], 13'd0};
      end
      if (ex == 5'h1F) begin
         return {h[15], 8'hFF, man, 13'd0};
      end
      return {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
   endfunction

endpackage

// ----- hw/rtl/tuf_lane.sv -----
// one conversion lane: raw channel word to single bits, registered
module tuf_lane (
   input  logic                clock,
   input  logic                enable,
   input  tuf_pkg::lane_ctl_type ctl,
   input  logic [31:0]         raw,
   input  logic [31:0]         absent_value,
   output logic [31:0]         conv_ff
);

   logic [31:0] conv_in;

   always_comb begin
      case (ctl.kind)
         tuf_pkg::KIND_UNORM8: conv_in = tuf_pkg::unorm8_to_single(raw[7:0]);
         tuf_pkg::KIND_HALF:   conv_in = tuf_pkg::half_to_single(raw[15:0]);
         default:              conv_in = raw;
      endcase
      if (!ctl.present) begin
         conv_in = absent_value;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         conv_ff <= conv_in;
      end
   end

endmodule

// ----- hw/rtl/tuf_premul.sv -----
// single-precision multiply by alpha for premultiplied unorm8 colour, or colour passed through on bypass, registered
module tuf_premul (
   input  logic        clock,
   input  logic        enable,
   input  logic        bypass,
   input  logic [31:0] colour,
   input  logic [31:0] alpha,
   output logic [31:0] result_ff
);

   // operands are 0 or in [2^-8,1], so no overflow, no subnormal results
   logic [47:0] prod;
   logic [23:0] mant;
   logic [24:0] rnd;
   logic        rbit;
   logic        sticky;
   logic [8:0]  ex;
   logic [31:0] result_in;

   always_comb begin
      prod = {1'b1, colour[22:0]} * {1'b1, alpha[22:0]};
      ex = {1'b0, colour[30:23]} + {1'b0, alpha[30:23]} - 9'd127;
      if (prod[47]) begin
         mant = prod[47:24];
         rbit = prod[23];
         sticky = |prod[22:0];
         ex = ex + 9'd1;
      end else begin
         mant = prod[46:23];
         rbit = prod[22];
         sticky = |prod[21:0];
      end
      rnd = {1'b0, mant} + {24'd0, rbit & (sticky | mant[0])};
      if (rnd[24]) begin
         result_in = {1'b0, ex[7:0] + 8'd1, 23'd0};
      end else begin
         result_in = {1'b0, ex[7:0], rnd[22:0]};
      end
      if (colour[30:0] == 31'd0 || alpha[30:0] == 31'd0) begin
         result_in = 32'd0;
      end
      if (bypass) begin
         result_in = colour;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

endmodule

// ----- hw/rtl/texel_unpack_to_float.sv -----
// top level: four conversion lanes, swap and premultiply merge, output register
// One texel per clock: a word is taken every cycle while the output side
// accepts, and its result passes through the lane register and then the
// premultiply register; a two-entry pipeline with valid bits, stalled as a
// whole when the output word is not taken. The registers take effect on the
// next texel accepted.
module texel_unpack_to_float (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_raw_ch0,
   input  logic [31:0] req_raw_ch1,
   input  logic [31:0] req_raw_ch2,
   input  logic [31:0] req_raw_ch3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_red,
   output logic [31:0] rsp_out_green,
   output logic [31:0] rsp_out_blue,
   output logic [31:0] rsp_out_alpha,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [2:0]  csr_data
);

   logic [1:0] kind_ff, kind_in;
   logic [2:0] count_ff, count_in;
   logic       swap_ff, swap_in;
   logic       s1_valid_ff, s1_valid_in;
   logic       s2_valid_ff, s2_valid_in;
   logic       s1_premul_ff;
   logic       s1_swap_ff;
   logic       advance;
   logic [2:0] n;
   tuf_pkg::kind_type kind;
   logic [31:0] raw [4];
   logic [31:0] conv [4];
   logic [31:0] col [3];

   assign advance   = !s2_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = s2_valid_ff;
   assign kind      = tuf_pkg::kind_type'(kind_ff);
   assign n         = (count_ff > 3'd4) ? 3'd4 : count_ff;
   assign raw[0] = req_raw_ch0;
   assign raw[1] = req_raw_ch1;
   assign raw[2] = req_raw_ch2;
   assign raw[3] = req_raw_ch3;

   always_comb begin
      kind_in  = kind_ff;
      count_in = count_ff;
      swap_in  = swap_ff;
      if (csr_write) begin
         case (csr_index)
            tuf_pkg::CSR_KIND:  kind_in  = csr_data[1:0];
            tuf_pkg::CSR_COUNT: count_in = csr_data;
            tuf_pkg::CSR_SWAP:  swap_in  = csr_data[0];
            default: ;
         endcase
      end
      s1_valid_in = advance ? req_valid : s1_valid_ff;
      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= tuf_pkg::KIND_UNORM8;
         count_ff    <= 3'd4;
         swap_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         kind_ff     <= kind_in;
         count_ff    <= count_in;
         swap_ff     <= swap_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_premul_ff <= (kind == tuf_pkg::KIND_UNORM8) && (n == 3'd4);
         s1_swap_ff   <= swap_ff;
      end
   end

   for (genvar g = 0; g < tuf_pkg::LaneCount; g++) begin : g_lane
      tuf_pkg::lane_ctl_type ctl;
      assign ctl.kind    = kind;
      assign ctl.present = (3'(g) < n);
      tuf_lane u_lane (
         .clock        (clock),
         .enable       (advance),
         .ctl          (ctl),
         .raw          (raw[g]),
         .absent_value ((g == 3) ? tuf_pkg::FloatOne : 32'd0),
         .conv_ff      (conv[g])
      );
   end

   assign col[0] = s1_swap_ff ? conv[2] : conv[0];
   assign col[1] = conv[1];
   assign col[2] = s1_swap_ff ? conv[0] : conv[2];

   tuf_premul u_mul_r (
      .clock(clock), .enable(advance), .bypass(!s1_premul_ff),
      .colour(col[0]), .alpha(conv[3]), .result_ff(rsp_out_red));
   tuf_premul u_mul_g (
      .clock(clock), .enable(advance), .bypass(!s1_premul_ff),
      .colour(col[1]), .alpha(conv[3]), .result_ff(rsp_out_green));
   tuf_premul u_mul_b (
      .clock(clock), .enable(advance), .bypass(!s1_premul_ff),
      .colour(col[2]), .alpha(conv[3]), .result_ff(rsp_out_blue));

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_out_alpha <= conv[3];
      end
   end

endmodule
